FILE: sv/mppt_pkg.sv
// Shared types, register map and reset constants for the MPPT tracker.
`timescale 1ns / 1ps

package mppt_pkg;

   localparam int DUTY_W    = 8;
   localparam int ALPHA_W   = 9;
   localparam int BAND_W    = 20;
   localparam int HYST_W    = 16;
   localparam int FRAC_BITS = 8;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Q1.8 unity; larger alpha values saturate to it
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   localparam logic [DUTY_W-1:0] DUTY_CENTER_RESET = 8'd127;

   typedef enum logic [2:0] {
      REG_DUTY_LO     = 3'd0,
      REG_DUTY_HI     = 3'd1,
      REG_DUTY_CENTER = 3'd2,
      REG_DUTY_INC    = 3'd3,
      REG_ALPHA_Q8    = 3'd4,
      REG_POWER_BAND  = 3'd5,
      REG_VOLT_HYST   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty_lo;
      logic [DUTY_W-1:0]  duty_hi;
      logic [DUTY_W-1:0]  duty_center;
      logic [DUTY_W-1:0]  duty_inc;
      logic [ALPHA_W-1:0] alpha_q8;
      logic [BAND_W-1:0]  power_band;
      logic [HYST_W-1:0]  volt_hyst;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      duty_lo:     8'd30,
      duty_hi:     8'd230,
      duty_center: DUTY_CENTER_RESET,
      duty_inc:    8'd6,
      alpha_q8:    9'd77,
      power_band:  20'd30,
      volt_hyst:   16'd10
   };

   // Observation flags handed from the filter stage to the duty stage
   typedef struct packed {
      logic first;     // seeding sample: load mid duty
      logic rise;      // filtered power rose beyond the dead band
      logic fall;      // filtered power fell beyond the dead band
      logic recenter;  // voltage drifted beyond the hysteresis
   } obs_type;

endpackage

FILE: sv/mppt_csr.sv
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module mppt_csr import mppt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          write_en;
   reg_index_type index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_DUTY_LO:     cfg_in.duty_lo     = csr_pwdata[DUTY_W-1:0];
            REG_DUTY_HI:     cfg_in.duty_hi     = csr_pwdata[DUTY_W-1:0];
            REG_DUTY_CENTER: cfg_in.duty_center = csr_pwdata[DUTY_W-1:0];
            REG_DUTY_INC:    cfg_in.duty_inc    = csr_pwdata[DUTY_W-1:0];
            REG_ALPHA_Q8:    cfg_in.alpha_q8    = csr_pwdata[ALPHA_W-1:0];
            REG_POWER_BAND:  cfg_in.power_band  = csr_pwdata[BAND_W-1:0];
            REG_VOLT_HYST:   cfg_in.volt_hyst   = csr_pwdata[HYST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DUTY_LO:     csr_prdata = CSR_DATA_W'(cfg_ff.duty_lo);
         REG_DUTY_HI:     csr_prdata = CSR_DATA_W'(cfg_ff.duty_hi);
         REG_DUTY_CENTER: csr_prdata = CSR_DATA_W'(cfg_ff.duty_center);
         REG_DUTY_INC:    csr_prdata = CSR_DATA_W'(cfg_ff.duty_inc);
         REG_ALPHA_Q8:    csr_prdata = CSR_DATA_W'(cfg_ff.alpha_q8);
         REG_POWER_BAND:  csr_prdata = CSR_DATA_W'(cfg_ff.power_band);
         REG_VOLT_HYST:   csr_prdata = CSR_DATA_W'(cfg_ff.volt_hyst);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/mppt_observe.sv
// Power filter and voltage drift stage: updates filter and baseline, emits flags.
`timescale 1ns / 1ps

module mppt_observe import mppt_pkg::*; #(
   parameter int POWER_BITS   = 20,
   parameter int VOLTAGE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [POWER_BITS-1:0]   power_mw,
   input  logic [VOLTAGE_BITS-1:0] voltage,
   output logic                    out_valid,
   input  logic                    out_ready,
   output obs_type                 obs
);

   localparam int FILT_W   = POWER_BITS + FRAC_BITS;
   localparam int DIFF_W   = FILT_W + 1;
   localparam int PROD_W   = DIFF_W + ALPHA_W + 1;
   localparam int STEP_W   = PROD_W - FRAC_BITS;
   localparam int BANDQ_W  = BAND_W + FRAC_BITS + 1;
   localparam int CMP_W    = (STEP_W > BANDQ_W) ? STEP_W : BANDQ_W;
   localparam int VCMP_W   = (VOLTAGE_BITS > HYST_W) ? VOLTAGE_BITS : HYST_W;
   localparam int ROUND_HALF = 2 ** (FRAC_BITS - 1);

   logic                    valid_ff;
   logic                    first_ff, first_in;
   logic [FILT_W-1:0]       filt_ff, filt_in;
   logic [VOLTAGE_BITS-1:0] base_ff, base_in;
   obs_type                 obs_ff, obs_in;

   logic                     fire;
   logic [ALPHA_W-1:0]       alpha_sat;
   logic [FILT_W-1:0]        sample_q;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] rounded;
   logic signed [STEP_W-1:0] step;
   logic [STEP_W-1:0]        filt_sum;
   logic signed [CMP_W-1:0]  step_ext;
   logic signed [CMP_W-1:0]  band_ext;
   logic [VOLTAGE_BITS-1:0]  drift;

   assign in_ready  = !valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign obs       = obs_ff;

   // EMA written as filt + alpha*(sample - filt), rounded half up
   assign alpha_sat = (cfg.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q8;
   assign sample_q  = {power_mw, {FRAC_BITS{1'b0}}};
   assign diff      = signed'({1'b0, sample_q}) - signed'({1'b0, filt_ff});
   assign prod      = PROD_W'(diff) * PROD_W'(signed'({1'b0, alpha_sat}));
   assign rounded   = prod + PROD_W'(ROUND_HALF);
   assign step      = rounded[PROD_W-1:FRAC_BITS];
   assign filt_sum  = STEP_W'(filt_ff) + step;

   // the step is exactly the change in filtered power
   assign step_ext = CMP_W'(step);
   assign band_ext = CMP_W'({1'b0, cfg.power_band, {FRAC_BITS{1'b0}}});

   assign drift = (voltage >= base_ff) ? voltage - base_ff : base_ff - voltage;

   always_comb begin
      first_in = first_ff;
      filt_in  = filt_ff;
      base_in  = base_ff;
      obs_in   = obs_ff;
      if (fire) begin
         if (first_ff) begin
            first_in        = 1'b0;
            filt_in         = sample_q;
            base_in         = voltage;
            obs_in          = '0;
            obs_in.first    = 1'b1;
         end else begin
            filt_in         = filt_sum[FILT_W-1:0];
            obs_in.first    = 1'b0;
            obs_in.rise     = step_ext > band_ext;
            obs_in.fall     = step_ext < -band_ext;
            obs_in.recenter = VCMP_W'(drift) > VCMP_W'(cfg.volt_hyst);
            if (obs_in.recenter) begin
               base_in = voltage;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         first_ff <= 1'b1;
         filt_ff  <= '0;
         base_ff  <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         first_ff <= first_in;
         filt_ff  <= filt_in;
         base_ff  <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      obs_ff <= obs_in;
   end

endmodule

FILE: sv/mppt_perturb.sv
// Duty perturbation, direction control, clamp and result register.
`timescale 1ns / 1ps

module mppt_perturb import mppt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  obs_type           obs,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DUTY_W-1:0] duty
);

   localparam int SUM_W = DUTY_W + 2;

   logic              valid_ff;
   logic              climb_ff, climb_in;
   logic [DUTY_W-1:0] duty_now_ff, duty_now_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;

   logic                    fire;
   logic                    climb_next;
   logic signed [SUM_W-1:0] d_step;
   logic signed [SUM_W-1:0] d_sel;
   logic signed [SUM_W-1:0] d_lo;
   logic signed [SUM_W-1:0] d_hi;
   logic signed [SUM_W-1:0] step_s;
   logic signed [SUM_W-1:0] min_s;
   logic signed [SUM_W-1:0] max_s;
   logic signed [SUM_W-1:0] mid_s;

   assign in_ready  = !valid_ff || rsp_ready;
   assign fire      = in_valid && in_ready;
   assign rsp_valid = valid_ff;
   assign duty      = duty_ff;

   assign step_s = signed'({2'b00, cfg.duty_inc});
   assign min_s  = signed'({2'b00, cfg.duty_lo});
   assign max_s  = signed'({2'b00, cfg.duty_hi});
   assign mid_s  = signed'({2'b00, cfg.duty_center});

   always_comb begin
      climb_next = climb_ff ^ obs.fall;
      d_step     = signed'({2'b00, duty_now_ff});
      if (obs.rise || obs.fall) begin
         d_step = climb_next ? d_step + step_s : d_step - step_s;
      end
      d_sel = d_step;
      if (obs.recenter) begin
         d_sel      = mid_s;
         climb_next = 1'b1;
      end
      // lower bound first, so min above max ends at max
      d_lo = (d_sel < min_s) ? min_s : d_sel;
      d_hi = (d_lo > max_s) ? max_s : d_lo;
   end

   always_comb begin
      climb_in    = climb_ff;
      duty_now_in = duty_now_ff;
      duty_in     = duty_ff;
      if (fire) begin
         if (obs.first) begin
            duty_now_in = cfg.duty_center;
            duty_in     = cfg.duty_center;
         end else begin
            climb_in    = climb_next;
            duty_now_in = d_hi[DUTY_W-1:0];
            duty_in     = d_hi[DUTY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         climb_ff    <= 1'b1;
         duty_now_ff <= DUTY_CENTER_RESET;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         climb_ff    <= climb_in;
         duty_now_ff <= duty_now_in;
      end
   end

   always_ff @(posedge clock) begin
      duty_ff <= duty_in;
   end

endmodule

FILE: sv/mppt_perturb_observe.sv
// Top level of the perturb-and-observe maximum power point tracker.
`timescale 1ns / 1ps
//
//  channel   dir  handshake                 payload
//  req_      in   req_tvalid / req_tready   power_mw, voltage
//  rsp_      out  rsp_tvalid / rsp_tready   duty
//  csr_      in   psel+penable+pwrite       7 config registers at 4*i
//
// One transaction in per clock unless rsp_ stalls, one duty out per sample; the
// stages are the input register, filter/drift stage and duty stage with the result
// register. The filter loop (subtract, 29x10 multiply, add) closes in the filter
// stage and the duty loop (step, clamp) in the duty stage.
// A stalled rsp_ fills the pipeline bubbles first; req_tready drops once all
// three stages hold data. Reset loads the default registers and re-arms the
// seeding of the filter and the voltage baseline by the next sample.

module mppt_perturb_observe import mppt_pkg::*; #(
   parameter int POWER_BITS   = 20,
   parameter int VOLTAGE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [POWER_BITS-1:0] power_mw, next VOLTAGE_BITS voltage, zero pad to bytes
   input  logic [((POWER_BITS + VOLTAGE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] duty
   output logic [DUTY_W-1:0]     rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   logic                    in_valid_ff;
   logic [POWER_BITS-1:0]   power_ff;
   logic [VOLTAGE_BITS-1:0] voltage_ff;

   logic    obs_ready;
   logic    obs_valid;
   logic    duty_ready;
   obs_type obs;
   logic    req_fire;

   mppt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   assign req_tready = !in_valid_ff || obs_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         power_ff   <= req_tdata[POWER_BITS-1:0];
         voltage_ff <= req_tdata[POWER_BITS + VOLTAGE_BITS - 1:POWER_BITS];
      end
   end

   mppt_observe #(
      .POWER_BITS   (POWER_BITS),
      .VOLTAGE_BITS (VOLTAGE_BITS)
   ) u_observe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_ready  (obs_ready),
      .power_mw  (power_ff),
      .voltage   (voltage_ff),
      .out_valid (obs_valid),
      .out_ready (duty_ready),
      .obs       (obs)
   );

   mppt_perturb u_perturb (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (obs_valid),
      .in_ready  (duty_ready),
      .obs       (obs),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .duty      (rsp_tdata)
   );

endmodule
